// ----- hdl/lpf_pkg.sv -----
// Shared types and constants for the largest prime factor block.
package lpf_pkg;

  // Default operand width.
  localparam int VALUE_BITS_DEF = 31;

  // The only even prime, and the first odd trial divisor.
  localparam int PRIME_TWO = 2;
  localparam int FIRST_ODD_DIV = 3;
  localparam int DIV_STEP = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic div_start;
    logic reduce;
    logic next_div;
    logic settle;
    logic publish;
  } lpf_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic n_small;
    logic n_even;
    logic div_done;
    logic d_gt_q;
    logic rem_zero;
  } lpf_status_t;

endpackage

// ----- hdl/lpf_in_if.sv -----
// Input channel interface: valid, ready and the operand.
interface lpf_in_if #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ----- hdl/lpf_out_if.sv -----
// Output channel interface: valid, ready and the result fields.
interface lpf_out_if #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] largest_factor;
  logic                  has_factor;

  modport source (output valid, output largest_factor, output has_factor, input ready);
  modport sink (input valid, input largest_factor, input has_factor, output ready);
endinterface

// ----- hdl/largest_prime_factor.sv -----
// Top level of the largest prime factor block.
//
// Each input transaction carries one unsigned value; the block returns its
// largest prime factor by trial division, with has_factor low and a zero
// factor for inputs 0 and 1. Work is sequential, one transaction at a time:
// factors of two are stripped one trailing zero bit at a time, then each
// trial division runs on a restoring serial divider in a start step, one
// shift step per quotient bit and a completion step. A divisor that divides
// is divided out before the next odd divisor is tried, and the search stops
// at the first odd divisor whose square exceeds the reduced value. A
// finished result waits in an output register, so a new input transaction
// is taken while the previous result is still pending.
module largest_prime_factor #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  lpf_in_if.sink     in_ch,
  lpf_out_if.source  out_ch
);
  import lpf_pkg::*;

  lpf_cmd_t    cmd;
  lpf_status_t status;

  lpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lpf_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .value         (in_ch.value),
    .largest_factor(out_ch.largest_factor),
    .has_factor    (out_ch.has_factor)
  );

endmodule

// ----- hdl/lpf_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module lpf_div #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder,
  output logic                  done
);
  import lpf_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] rem_next;
  logic [CNT_W-1:0]      count;
  logic                  busy;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  // Shift the next dividend bit into the partial remainder and try to subtract.
  always_comb begin
    trial    = {rem, quo[VALUE_BITS-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
  end

  // Iteration registers; the dividend register fills with quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(VALUE_BITS - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_BITS-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  // A new division is never started on top of a running one.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

  // Completion is a single-cycle pulse.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for more than one cycle");

  // Completion is only flagged once the shifting has stopped.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

// ----- hdl/lpf_datapath.sv -----
// Datapath: reduced value, trial divisor, best factor, divider and result register.
module lpf_datapath #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpf_pkg::lpf_cmd_t     cmd,
  output lpf_pkg::lpf_status_t  status,
  input  logic [VALUE_BITS-1:0] value,
  output logic [VALUE_BITS-1:0] largest_factor,
  output logic                  has_factor
);
  import lpf_pkg::*;

  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS-1:0] best;
  logic [VALUE_BITS-1:0] result;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] rem;
  logic                  div_done;

  lpf_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (n),
    .divisor  (d),
    .quotient (quo),
    .remainder(rem),
    .done     (div_done)
  );

  // Working registers, updated one command at a time.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n    <= value;
      d    <= VALUE_BITS'(FIRST_ODD_DIV);
      best <= '0;
    end else if (cmd.shift) begin
      n    <= n >> 1;
      best <= VALUE_BITS'(PRIME_TWO);
    end else if (cmd.reduce) begin
      n    <= quo;
      best <= d;
    end else if (cmd.next_div) begin
      d <= d + VALUE_BITS'(DIV_STEP);
    end else if (cmd.settle) begin
      if (n > VALUE_BITS'(PRIME_TWO)) begin
        best <= n;
      end
    end
  end

  // Result register; it frees the working registers for the next transaction.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result <= best;
    end
  end

  assign largest_factor = result;
  assign has_factor     = |result;

  // Status for the controller. The square test d*d <= n is d <= n / d.
  always_comb begin
    status          = '0;
    status.n_small  = (n[VALUE_BITS-1:1] == '0);
    status.n_even   = !n[0];
    status.div_done = div_done;
    status.d_gt_q   = (d > quo);
    status.rem_zero = (rem == '0);
  end

endmodule

// ----- hdl/lpf_ctrl.sv -----
// Controller state machine that sequences the factoring steps.
module lpf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lpf_pkg::lpf_status_t status,
  output lpf_pkg::lpf_cmd_t    cmd
);
  import lpf_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    STRIP,
    START,
    DIV,
    FINISH
  } state_t;

  state_t state;

  // Commands depend on the state and the datapath status.
  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.load = in_valid;
      end
      STRIP: begin
        if (!status.n_small) begin
          if (status.n_even) begin
            cmd.shift = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
          end
        end
      end
      START: begin
        cmd.div_start = 1'b1;
      end
      DIV: begin
        if (status.div_done) begin
          if (status.d_gt_q) begin
            cmd.settle = 1'b1;
          end else if (status.rem_zero) begin
            cmd.reduce = 1'b1;
          end else begin
            cmd.next_div = 1'b1;
          end
        end
      end
      FINISH: begin
        cmd.publish = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign in_ready = (state == IDLE);

  // State and output-valid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= STRIP;
          end
        end
        STRIP: begin
          if (status.n_small) begin
            state <= FINISH;
          end else if (!status.n_even) begin
            state <= DIV;
          end
        end
        START: begin
          state <= DIV;
        end
        DIV: begin
          if (status.div_done) begin
            state <= status.d_gt_q ? FINISH : START;
          end
        end
        FINISH: begin
          if (cmd.publish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // At most one datapath command in any cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.shift, cmd.div_start, cmd.reduce, cmd.next_div,
              cmd.settle, cmd.publish}))
    else $error("conflicting datapath commands");

  // A result is never written over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // A settled item reaches the result stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.settle |=> (state == FINISH))
    else $error("settle not followed by finish");

endmodule
